// ===== src/lookup2_byte_stream_hash_macros.svh =====
`ifndef LOOKUP2_BYTE_STREAM_HASH_MACROS_SVH
`define LOOKUP2_BYTE_STREAM_HASH_MACROS_SVH

// Implication that must hold at every clock edge once reset is released.
`define LH2_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lh2: implication check failed");

// Invariant that must hold at every clock edge once reset is released.
`define LH2_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("lh2: invariant check failed");

`endif

// ===== src/lh2_pkg.sv =====
package lh2_pkg;

	// Golden ratio constant that seeds mix words a and b.
	localparam logic [31:0] GOLDEN = 32'h9e37_79b9;

	// Configuration reset values.
	localparam logic [31:0] SEED_RESET       = 32'd23312819;
	localparam logic [5:0]  INDEX_BITS_RESET = 6'd10;

	// Configuration register indexes.
	localparam int                     CFG_INDEX_W    = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_SEED       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS = 2'd1;

	// Position of the byte that completes a 12-byte block.
	localparam logic [3:0] BLOCK_LAST = 4'd11;

	// One mix row per pipeline stage.
	localparam int MIX_STAGES = 9;

	// Default number of result entries the output queue can hold.
	localparam int OUT_DEPTH = 32;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       last_item;
	} key_item_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} mix_word_t;

	// A job in the mix pipeline: a block mix or the final mix of a key.
	typedef struct packed {
		logic      vld;
		logic      fin;
		mix_word_t w;
	} mix_job_t;

	// One row of the lookup2 mix. Each row updates a single word from the other two.
	function automatic mix_word_t mix_row(input mix_word_t w, input int unsigned row);
		mix_word_t r;
		r = w;
		unique case (row)
			0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
			1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
			2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
			3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
			4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
			5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
			6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
			7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
			8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
			default: r = w;
		endcase
		return r;
	endfunction

endpackage

// ===== src/lh2_stream_if.sv =====
// Key byte channel.
interface lh2_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last_item;

	modport source (output valid, data_byte, byte_present, last_item, input ready);
	modport sink (input valid, data_byte, byte_present, last_item, output ready);
endinterface

// Hash result channel.
interface lh2_hash_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;
	logic [31:0] bucket_index;

	modport source (output valid, hash_value, bucket_index, input ready);
	modport sink (input valid, hash_value, bucket_index, output ready);
endinterface

// ===== src/lh2_mixpipe.sv =====
module lh2_mixpipe import lh2_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mix_job_t issue,
	output mix_job_t result
);

	mix_word_t word_s [MIX_STAGES];
	logic      vld_s  [MIX_STAGES];
	logic      fin_s  [MIX_STAGES];

	// Each stage applies one mix row; the job tag travels alongside.
	for (genvar k = 0; k < MIX_STAGES; k++) begin : g_stage
		mix_word_t w_in;
		logic      v_in;
		logic      f_in;

		if (k == 0) begin : g_head
			assign w_in = issue.w;
			assign v_in = issue.vld;
			assign f_in = issue.fin;
		end else begin : g_body
			assign w_in = word_s[k-1];
			assign v_in = vld_s[k-1];
			assign f_in = fin_s[k-1];
		end

		always_ff @(posedge clk) begin
			word_s[k] <= mix_row(w_in, k);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
				fin_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
				fin_s[k] <= f_in;
			end
		end
	end

	assign result.vld = vld_s[MIX_STAGES-1];
	assign result.fin = fin_s[MIX_STAGES-1];
	assign result.w   = word_s[MIX_STAGES-1];

endmodule

// ===== src/lh2_accum.sv =====
`include "lookup2_byte_stream_hash_macros.svh"

module lh2_accum import lh2_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  key_item_t   item,
	input  logic [31:0] seed_cfg,
	input  logic        seed_load,
	input  logic [31:0] seed_wdata,
	input  mix_job_t    result,
	output mix_job_t    issue
);

	// A final job waits until a block mix issued in the same beat has left the pipeline.
	localparam int FIN_DEPTH = MIX_STAGES + 1;
	localparam int TAIL      = FIN_DEPTH - 1;

	// Per-key state.
	logic [3:0]  pos_q;
	logic [31:0] wa_q;
	logic [31:0] wb_q;
	logic [23:0] stg_q;
	logic [31:0] len_q;
	logic        mixed_q;
	logic [31:0] init_c_q;
	mix_word_t   base_q;

	// Issue register feeding the mix pipeline.
	logic        issue_vld_q;
	logic        issue_fin_q;
	mix_word_t   issue_word_q;

	// Final-job delay line.
	logic        fin_vld_s   [FIN_DEPTH];
	logic        fin_blk_s   [FIN_DEPTH];
	logic        fin_mixed_s [FIN_DEPTH];
	logic [31:0] fin_initc_s [FIN_DEPTH];
	mix_word_t   fin_add_s   [FIN_DEPTH];

	logic        take;
	logic        blk_done;
	logic        fin_now;
	logic [3:0]  pos_n;
	logic [31:0] wa_n;
	logic [31:0] wb_n;
	logic [23:0] stg_n;
	logic [31:0] len_n;
	logic        mixed_n;
	logic [4:0]  lane_ofs;
	mix_word_t   cur_base;
	mix_word_t   blk_word;
	mix_word_t   fin_add_n;
	mix_word_t   re_base;
	mix_word_t   re_word;

	// Byte placement within the current block and the block mix input.
	always_comb begin
		take     = fire && item.byte_present;
		fin_now  = fire && item.last_item;
		blk_done = 1'b0;
		lane_ofs = {pos_q[1:0], 3'b000};
		pos_n    = pos_q;
		wa_n     = wa_q;
		wb_n     = wb_q;
		stg_n    = stg_q;
		len_n    = len_q + {31'd0, take};
		if (take) begin
			pos_n = pos_q + 4'd1;
			unique case (pos_q[3:2])
				2'b00: wa_n[lane_ofs +: 8] = item.data_byte;
				2'b01: wb_n[lane_ofs +: 8] = item.data_byte;
				2'b10: begin
					if (pos_q == BLOCK_LAST) begin
						blk_done = 1'b1;
						pos_n    = '0;
						wa_n     = '0;
						wb_n     = '0;
						stg_n    = '0;
					end else begin
						stg_n[lane_ofs +: 8] = item.data_byte;
					end
				end
				default: pos_n = '0;
			endcase
		end
		mixed_n = mixed_q || blk_done;

		cur_base = mixed_q ? base_q : mix_word_t'{a: GOLDEN, b: GOLDEN, c: init_c_q};
		blk_word.a = cur_base.a + wa_q;
		blk_word.b = cur_base.b + wb_q;
		blk_word.c = cur_base.c + {item.data_byte, stg_q};

		// Tail bytes for c sit one byte higher; the length goes into c as well.
		fin_add_n.a = wa_n;
		fin_add_n.b = wb_n;
		fin_add_n.c = len_n + {stg_n, 8'h00};
	end

	// The final mix starts from the last block mix of its key, or from the initial words.
	always_comb begin
		if (fin_blk_s[TAIL]) begin
			re_base = result.w;
		end else if (fin_mixed_s[TAIL]) begin
			re_base = base_q;
		end else begin
			re_base = '{a: GOLDEN, b: GOLDEN, c: fin_initc_s[TAIL]};
		end
		re_word.a = re_base.a + fin_add_s[TAIL].a;
		re_word.b = re_base.b + fin_add_s[TAIL].b;
		re_word.c = re_base.c + fin_add_s[TAIL].c;
	end

	// Key state update; a final beat re-arms for the next key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			wa_q     <= '0;
			wb_q     <= '0;
			stg_q    <= '0;
			len_q    <= '0;
			mixed_q  <= 1'b0;
			init_c_q <= SEED_RESET;
		end else begin
			if (fin_now) begin
				pos_q    <= '0;
				wa_q     <= '0;
				wb_q     <= '0;
				stg_q    <= '0;
				len_q    <= '0;
				mixed_q  <= 1'b0;
				init_c_q <= seed_cfg;
			end else begin
				pos_q   <= pos_n;
				wa_q    <= wa_n;
				wb_q    <= wb_n;
				stg_q   <= stg_n;
				len_q   <= len_n;
				mixed_q <= mixed_n;
			end
			if (seed_load && len_q == '0) begin
				init_c_q <= seed_wdata;
			end
		end
	end

	// Latest block mix result of the current key.
	always_ff @(posedge clk) begin
		if (result.vld && !result.fin) begin
			base_q <= result.w;
		end else if (seed_load && len_q == '0 && mixed_q) begin
			base_q.c <= seed_wdata;
		end
	end

	// Issue either a block mix or a delayed final mix; they never fall on the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_vld_q <= 1'b0;
			issue_fin_q <= 1'b0;
		end else begin
			issue_vld_q <= blk_done || fin_vld_s[TAIL];
			issue_fin_q <= !blk_done && fin_vld_s[TAIL];
		end
	end

	always_ff @(posedge clk) begin
		issue_word_q <= blk_done ? blk_word : re_word;
	end

	assign issue.vld = issue_vld_q;
	assign issue.fin = issue_fin_q;
	assign issue.w   = issue_word_q;

	// Final-job delay line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FIN_DEPTH; k++) begin
				fin_vld_s[k] <= 1'b0;
			end
		end else begin
			fin_vld_s[0] <= fin_now;
			for (int k = 1; k < FIN_DEPTH; k++) begin
				fin_vld_s[k] <= fin_vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		fin_blk_s[0]   <= blk_done;
		fin_mixed_s[0] <= mixed_n;
		fin_initc_s[0] <= init_c_q;
		fin_add_s[0]   <= fin_add_n;
		for (int k = 1; k < FIN_DEPTH; k++) begin
			fin_blk_s[k]   <= fin_blk_s[k-1];
			fin_mixed_s[k] <= fin_mixed_s[k-1];
			fin_initc_s[k] <= fin_initc_s[k-1];
			fin_add_s[k]   <= fin_add_s[k-1];
		end
	end

	`LH2_ASSERT_IMPL(a_issue_no_clash, clk, arst_n, blk_done, !fin_vld_s[TAIL])
	`LH2_ASSERT_ALWAYS(a_pos_in_block, clk, arst_n, pos_q <= BLOCK_LAST)

endmodule

// ===== src/lh2_out_fifo.sv =====
`include "lookup2_byte_stream_hash_macros.svh"

module lh2_out_fifo import lh2_pkg::*; #(
	parameter int DEPTH = OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        reserve,
	input  logic        push,
	input  logic [31:0] push_data,
	input  logic        pop,
	output logic        head_valid,
	output logic [31:0] head_data,
	output logic        can_reserve
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [31:0]      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] credit_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Stored results.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers, fill level and credits; a credit is held from the last beat of a key
	// until its hash leaves the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			fill_q   <= fill_q + CNT_W'(push) - CNT_W'(pop);
			credit_q <= credit_q + CNT_W'(reserve) - CNT_W'(pop);
		end
	end

	assign head_valid  = fill_q != '0;
	assign head_data   = mem_q[rd_ptr_q];
	assign can_reserve = credit_q < CNT_W'(DEPTH);

	`LH2_ASSERT_IMPL(a_push_not_full, clk, arst_n, push, fill_q < CNT_W'(DEPTH))
	`LH2_ASSERT_ALWAYS(a_fill_within_credit, clk, arst_n, fill_q <= credit_q)

endmodule

// ===== src/lookup2_byte_stream_hash.sv =====
// Streaming lookup2 hash over a key given one byte per beat.
// key_in carries data_byte, byte_present and last_item. A beat with byte_present
// low adds no byte; a beat with last_item high ends the key, so a lone beat with
// no byte and last_item high hashes an empty key.
// hash_out gives one beat per key: the 32-bit hash and the hash masked to the
// index_bits low bits (32 or more keeps all bits).
// Configuration: wr_en, wr_index and wr_data write seed (index 0) and index_bits
// (index 1) in the cycle wr_en is high; write only while no key is in flight.
// Throughput: one key beat per cycle while key_in.ready is high, including back-to-back keys.
// The last beat of a key passes a delay line and the issue register; a nine-row
// mix pipeline runs the block mix and then the final mix.
// Stalls: finished hashes wait in a queue of RES_DEPTH entries. key_in.ready is
// low while RES_DEPTH keys have ended whose hashes are not yet taken.
// Reset clears all key state and the queue; seed returns to 23312819 and
// index_bits to 10.
module lookup2_byte_stream_hash import lh2_pkg::*; #(
	parameter int RES_DEPTH = OUT_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [31:0]            wr_data,
	lh2_byte_if.sink               key_in,
	lh2_hash_if.source             hash_out
);

	logic [31:0] seed_q;
	logic [5:0]  index_bits_q;
	logic        seed_load;
	logic        in_fire;
	logic        out_fire;
	logic        can_reserve;
	logic [31:0] head_data;
	logic [31:0] index_mask;
	key_item_t   item;
	mix_job_t    issue;
	mix_job_t    result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= SEED_RESET;
			index_bits_q <= INDEX_BITS_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SEED:       seed_q       <= wr_data;
				REG_INDEX_BITS: index_bits_q <= wr_data[5:0];
				default:        ;
			endcase
		end
	end

	assign seed_load = wr_en && (wr_index == REG_SEED);

	// Input beat handshake.
	assign key_in.ready = can_reserve;
	assign in_fire      = key_in.valid && key_in.ready;
	assign item.data_byte    = key_in.data_byte;
	assign item.byte_present = key_in.byte_present;
	assign item.last_item    = key_in.last_item;

	lh2_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.item       (item),
		.seed_cfg   (seed_q),
		.seed_load  (seed_load),
		.seed_wdata (wr_data),
		.result     (result),
		.issue      (issue)
	);

	lh2_mixpipe u_mixpipe (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.result (result)
	);

	lh2_out_fifo #(
		.DEPTH (RES_DEPTH)
	) u_out_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.reserve     (in_fire && key_in.last_item),
		.push        (result.vld && result.fin),
		.push_data   (result.w.c),
		.pop         (out_fire),
		.head_valid  (hash_out.valid),
		.head_data   (head_data),
		.can_reserve (can_reserve)
	);

	// Output beat with the bucket mask applied.
	assign out_fire   = hash_out.valid && hash_out.ready;
	assign index_mask = index_bits_q[5] ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << index_bits_q[4:0]);
	assign hash_out.hash_value   = head_data;
	assign hash_out.bucket_index = head_data & index_mask;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import lh2_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 12;
	// Settling time after the last hash, with margin over the pipeline depth.
	localparam int SETTLE_CYCLES = 32;
	localparam int TIMEOUT_NS = 2_000_000;
	localparam int RANDOM_BEATS = 850;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	typedef struct packed {
		logic [31:0] hash_value;
		logic [31:0] bucket_index;
	} hash_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [31:0] wr_data;

	lh2_byte_if key_if ();
	lh2_hash_if hash_if ();

	lookup2_byte_stream_hash uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.key_in   (key_if),
		.hash_out (hash_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predicted hash state and configuration.
	logic [31:0] seed_reg;
	logic [5:0]  index_bits_reg;
	logic [31:0] acc_a;
	logic [31:0] acc_b;
	logic [31:0] acc_c;
	logic [3:0]  blk_pos;
	logic [23:0] c_tail;
	logic [31:0] key_len;

	hash_result_t pending_hashes[$];
	int fail_count = 0;
	int unsigned beats_sent = 0;

	// Sender and receiver idling controls.
	int unsigned burst_left = 0;
	int unsigned gap_max = 0;
	rx_mode_t rx_mode = RX_STEADY;
	int unsigned hold_cycles = 0;

	// The nine-row lookup2 mix over the predicted words.
	function automatic void stir_words();
		acc_a = (acc_a - acc_b - acc_c) ^ (acc_c >> 13);
		acc_b = (acc_b - acc_c - acc_a) ^ (acc_a << 8);
		acc_c = (acc_c - acc_a - acc_b) ^ (acc_b >> 13);
		acc_a = (acc_a - acc_b - acc_c) ^ (acc_c >> 12);
		acc_b = (acc_b - acc_c - acc_a) ^ (acc_a << 16);
		acc_c = (acc_c - acc_a - acc_b) ^ (acc_b >> 5);
		acc_a = (acc_a - acc_b - acc_c) ^ (acc_c >> 3);
		acc_b = (acc_b - acc_c - acc_a) ^ (acc_a << 10);
		acc_c = (acc_c - acc_a - acc_b) ^ (acc_b >> 15);
	endfunction

	function automatic void start_key();
		acc_a = GOLDEN;
		acc_b = GOLDEN;
		acc_c = seed_reg;
		blk_pos = 4'd0;
		c_tail = 24'd0;
		key_len = 32'd0;
	endfunction

	// Fold one key byte into its little-endian word; the twelfth byte mixes the block.
	function automatic void fold_byte(input logic [7:0] value);
		if (blk_pos < 4) begin
			acc_a += 32'(value) << (8 * blk_pos);
		end else if (blk_pos < 8) begin
			acc_b += 32'(value) << (8 * (blk_pos - 4));
		end else if (blk_pos < BLOCK_LAST) begin
			c_tail |= 24'(value) << (8 * (blk_pos - 8));
		end else begin
			acc_c += {8'h00, c_tail} + {value, 24'h000000};
			stir_words();
			c_tail = 24'd0;
		end
		blk_pos = (blk_pos == BLOCK_LAST) ? 4'd0 : blk_pos + 4'd1;
		key_len += 32'd1;
	endfunction

	// Update the prediction for one accepted beat and queue the hash a key end yields.
	function automatic void predict_beat(input logic [7:0] value, input logic present,
			input logic last);
		hash_result_t res;
		logic [31:0] mask;
		if (present)
			fold_byte(value);
		if (last) begin
			acc_c += key_len;
			acc_c += {c_tail, 8'h00};
			stir_words();
			mask = (index_bits_reg >= 6'd32) ? 32'hffff_ffff
				: (32'h1 << index_bits_reg) - 32'h1;
			res.hash_value = acc_c;
			res.bucket_index = acc_c & mask;
			pending_hashes.push_back(res);
			start_key();
		end
	endfunction

	// Offer one beat, honoring the burst and gap pattern, and wait until it is taken.
	task automatic send_beat(input logic [7:0] value, input logic present, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				key_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		key_if.valid <= 1'b1;
		key_if.data_byte <= value;
		key_if.byte_present <= present;
		key_if.last_item <= last;
		@(posedge clk);
		while (!key_if.ready)
			@(posedge clk);
		burst_left--;
		predict_beat(value, present, last);
		if (present || last)
			beats_sent++;
	endtask

	// Send a whole key. The end is marked either on its last byte or by a beat
	// that carries no byte; now and then an empty beat is slipped in.
	task automatic send_key(input int unsigned len);
		bit end_on_byte;
		int unsigned i;
		end_on_byte = (len != 0) && ($urandom_range(0, 3) != 0);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	function automatic int unsigned pick_key_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(27, 80);
		return $urandom_range(0, 26);
	endfunction

	// Stop offering beats and wait for every queued hash, then let the pipeline settle.
	task automatic drain_results();
		key_if.valid <= 1'b0;
		burst_left = 0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on two consecutive edges while the block is idle.
	task automatic configure(input logic [31:0] seed, input logic [5:0] bits);
		drain_results();
		wr_en <= 1'b1;
		wr_index <= REG_SEED;
		wr_data <= seed;
		@(posedge clk);
		seed_reg = seed;
		if (key_len == 32'd0)
			acc_c = seed;
		wr_index <= REG_INDEX_BITS;
		wr_data <= {26'd0, bits};
		@(posedge clk);
		index_bits_reg = bits;
		wr_en <= 1'b0;
	endtask

	// Receiver: check each accepted beat, then choose ready for the next edge.
	initial begin
		int unsigned rx_cycle;
		logic [15:0] stall_pattern;
		hash_result_t want;
		rx_cycle = 0;
		stall_pattern = 16'hffff;
		hash_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hash_if.valid && hash_if.ready) begin
				if (pending_hashes.size() == 0) begin
					$error("unexpected hash beat: hash_value %h bucket_index %h",
						hash_if.hash_value, hash_if.bucket_index);
					fail_count++;
				end else begin
					want = pending_hashes.pop_front();
					if (hash_if.hash_value !== want.hash_value) begin
						$error("hash_value: expected %h, actual %h",
							want.hash_value, hash_if.hash_value);
						fail_count++;
					end
					if (hash_if.bucket_index !== want.bucket_index) begin
						$error("bucket_index: expected %h, actual %h",
							want.bucket_index, hash_if.bucket_index);
						fail_count++;
					end
				end
			end
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				stall_pattern = 16'($urandom) | 16'h0001;
			if (hold_cycles != 0) begin
				hold_cycles--;
				hash_if.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_STEADY: hash_if.ready <= 1'b1;
					RX_RANDOM: hash_if.ready <= ($urandom_range(0, 3) != 0);
					default: hash_if.ready <= stall_pattern[rx_cycle % 16];
				endcase
			end
		end
	end

	// Extremes of the byte, empty keys, empty beats and a full block at reset settings.
	task automatic test_directed();
		int i;
		rx_mode = RX_STEADY;
		gap_max = 0;
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'ha5, 1'b0, 1'b0);
		send_beat(8'h3c, 1'b1, 1'b0);
		send_beat(8'h5a, 1'b0, 1'b0);
		send_beat(8'hc3, 1'b0, 1'b1);
		for (i = 0; i < 12; i++)
			send_beat(8'hff, 1'b1, i == 11);
		send_beat(8'h81, 1'b0, 1'b1);
		drain_results();
	endtask

	// Extreme seeds and index widths, including no mask at all and an empty mask.
	task automatic test_config_extremes();
		logic [31:0] seeds[4];
		logic [5:0] widths[4];
		int p;
		int unsigned target;
		seeds = '{32'h0000_0000, 32'hffff_ffff, 32'($urandom), 32'($urandom)};
		widths = '{6'd0, 6'd32, 6'd1, 6'd31};
		for (p = 0; p < 4; p++) begin
			configure(seeds[p], widths[p]);
			rx_mode = rx_mode_t'(p % 3);
			gap_max = (p % 2 == 0) ? 0 : 4;
			send_beat(8'h00, 1'b0, 1'b1);
			target = beats_sent + 50;
			while (beats_sent < target)
				send_key(pick_key_len());
		end
	endtask

	// Bulk random keys over several random settings and idling styles.
	task automatic test_random_keys();
		int unsigned stop_at;
		int unsigned phase_end;
		int p;
		stop_at = beats_sent + RANDOM_BEATS;
		p = 0;
		while (beats_sent < stop_at) begin
			configure(32'($urandom), 6'($urandom_range(0, 32)));
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 8);
			phase_end = beats_sent + 220;
			while (beats_sent < phase_end && beats_sent < stop_at)
				send_key(pick_key_len());
			p++;
		end
	endtask

	// The receiver holds off for a long stretch while short keys keep coming, so the
	// result queue fills and the key input stalls; then the sender waits for all hashes.
	task automatic test_backpressure();
		int i;
		configure(32'($urandom), 6'($urandom_range(0, 32)));
		rx_mode = RX_STEADY;
		gap_max = 0;
		hold_cycles = 400;
		for (i = 0; i < 60; i++) begin
			if (i % 7 == 3)
				send_beat(8'($urandom), 1'b0, 1'b1);
			else
				send_beat(8'($urandom), 1'b1, 1'b1);
		end
		drain_results();
		rx_mode = RX_PATTERN;
		gap_max = 2;
		for (i = 0; i < 20; i++)
			send_key(pick_key_len());
	endtask

	initial begin
		seed_reg = SEED_RESET;
		index_bits_reg = INDEX_BITS_RESET;
		start_key();
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_SEED;
		wr_data <= 32'd0;
		key_if.valid <= 1'b0;
		key_if.data_byte <= 8'd0;
		key_if.byte_present <= 1'b0;
		key_if.last_item <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_extremes();
		test_random_keys();
		test_backpressure();
		drain_results();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
